[rtl/clex_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package clex_pkg;

  // Fixed field widths.
  localparam int unsigned KIND_W     = 5;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned PREFIX_W   = 48;
  localparam int unsigned CNT2_W     = 2;

  // Token queue between the scanner and the output stage.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Keyword spellings, right-aligned: last character in the lowest byte.
  localparam logic [PREFIX_W-1:0] KW_INT    = 48'h0000_0069_6E74;
  localparam logic [PREFIX_W-1:0] KW_VOID   = 48'h0000_766F_6964;
  localparam logic [PREFIX_W-1:0] KW_RETURN = 48'h7265_7475_726E;

  localparam logic [LEN_W-1:0] LEN_INT    = 16'd3;
  localparam logic [LEN_W-1:0] LEN_VOID   = 16'd4;
  localparam logic [LEN_W-1:0] LEN_RETURN = 16'd6;
  localparam logic [LEN_W-1:0] LEN_PREFIX = 16'd6;
  localparam logic [LEN_W-1:0] LEN_ONE    = 16'd1;
  localparam logic [LEN_W-1:0] LEN_TWO    = 16'd2;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_TILDE      = 8'h7E;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_PERCENT    = 8'h25;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_BADNUM,
    MODE_IDENT,
    MODE_EQ,
    MODE_PLUS,
    MODE_MINUS
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    TK_EOF, TK_EQ, TK_ASSIGN, TK_INC, TK_ADDEQ, TK_ADD, TK_SEMI,
    TK_LBRACE, TK_RBRACE, TK_LPAREN, TK_RPAREN, TK_TILDE, TK_DEC,
    TK_SUBEQ, TK_MINUS, TK_MUL, TK_DIV, TK_REM, TK_INVALID, TK_CONST,
    TK_IDENT, TK_INT, TK_VOID, TK_RETURN
  } kind_e;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic kind_e single_kind(input logic [7:0] c);
    kind_e k;
    case (c)
      CH_SEMI:    k = TK_SEMI;
      CH_LBRACE:  k = TK_LBRACE;
      CH_RBRACE:  k = TK_RBRACE;
      CH_LPAREN:  k = TK_LPAREN;
      CH_RPAREN:  k = TK_RPAREN;
      CH_TILDE:   k = TK_TILDE;
      CH_STAR:    k = TK_MUL;
      CH_SLASH:   k = TK_DIV;
      CH_PERCENT: k = TK_REM;
      default:    k = TK_INVALID;
    endcase
    return k;
  endfunction

  function automatic kind_e ident_kind(input logic [LEN_W-1:0] len,
                                       input logic [PREFIX_W-1:0] pre);
    kind_e k;
    if (len == LEN_INT && pre == KW_INT) begin
      k = TK_INT;
    end else if (len == LEN_VOID && pre == KW_VOID) begin
      k = TK_VOID;
    end else if (len == LEN_RETURN && pre == KW_RETURN) begin
      k = TK_RETURN;
    end else begin
      k = TK_IDENT;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/clex_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

// Small token queue; an entry holds the tokens caused by one source byte.
module clex_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [clex_pkg::FIFO_DEPTH];
  logic [clex_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [clex_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [clex_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == clex_pkg::FIFO_CNT_W'(clex_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("token queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("token queue read while empty");
`endif

endmodule

`default_nettype wire

[rtl/clex_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

// Scanner: takes one byte per transaction, tracks the pending token and the
// source position, and pushes the tokens that the byte completes.
module clex_scan #(
  parameter int unsigned OB    = 24,
  parameter int unsigned LB    = 20,
  parameter int unsigned CB    = 16,
  parameter int unsigned TOK_W = clex_pkg::KIND_W + OB + clex_pkg::LEN_W + LB + CB,
  parameter int unsigned ENT_W = clex_pkg::CNT2_W + 2 * TOK_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             in_end_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output logic [ENT_W-1:0]      entry_o
);

  clex_pkg::mode_e mode_q, mode_d;
  logic [OB-1:0] tstart_q, tstart_d;
  logic [LB-1:0] tline_q, tline_d;
  logic [CB-1:0] tcol_q, tcol_d;
  logic [clex_pkg::LEN_W-1:0] tcnt_q, tcnt_d;
  logic [clex_pkg::PREFIX_W-1:0] pre_q, pre_d;
  logic [OB-1:0] off_q, off_d;
  logic [LB-1:0] line_q, line_d;
  logic [CB-1:0] col_q, col_d;

  logic acc, is_end, pend, ext, pair;
  logic [7:0] c;
  logic [OB-1:0] off_nx;
  logic [LB-1:0] line_nx;
  logic [CB-1:0] col_nx;
  logic [clex_pkg::LEN_W-1:0] tcnt_inc;
  clex_pkg::kind_e flush_kind, pair_kind;
  logic [TOK_W-1:0] flush_tok;
  logic a_v, b_v;
  logic [TOK_W-1:0] a_tok, b_tok;

  assign c          = in_byte_i;
  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;
  assign is_end     = in_end_i || (c == clex_pkg::CH_NUL);
  assign pend       = (mode_q != clex_pkg::MODE_IDLE);

  // Saturating position after this byte.
  assign off_nx   = (off_q == '1) ? off_q : off_q + 1'b1;
  assign line_nx  = (c != clex_pkg::CH_NEWLINE) ? line_q :
                    (line_q == '1) ? line_q : line_q + 1'b1;
  assign col_nx   = (c == clex_pkg::CH_NEWLINE) ? CB'(1) :
                    (col_q == '1) ? col_q : col_q + 1'b1;
  assign tcnt_inc = (tcnt_q == '1) ? tcnt_q : tcnt_q + 1'b1;

  always_comb begin
    case (mode_q)
      clex_pkg::MODE_NUM:    flush_kind = clex_pkg::TK_CONST;
      clex_pkg::MODE_BADNUM: flush_kind = clex_pkg::TK_INVALID;
      clex_pkg::MODE_IDENT:  flush_kind = clex_pkg::ident_kind(tcnt_q, pre_q);
      clex_pkg::MODE_EQ:     flush_kind = clex_pkg::TK_ASSIGN;
      clex_pkg::MODE_PLUS:   flush_kind = clex_pkg::TK_ADD;
      clex_pkg::MODE_MINUS:  flush_kind = clex_pkg::TK_MINUS;
      default:               flush_kind = clex_pkg::TK_EOF;
    endcase
  end

  assign flush_tok = {tcol_q, tline_q, tcnt_q, tstart_q, flush_kind};

  // Does the byte extend the pending token, or close a two-character operator?
  always_comb begin
    ext       = 1'b0;
    pair      = 1'b0;
    pair_kind = clex_pkg::TK_EQ;
    case (mode_q)
      clex_pkg::MODE_NUM: begin
        ext = clex_pkg::is_digit(c) || clex_pkg::is_alpha(c);
      end
      clex_pkg::MODE_BADNUM: begin
        ext = clex_pkg::is_digit(c) || clex_pkg::is_alpha(c);
      end
      clex_pkg::MODE_IDENT: begin
        ext = clex_pkg::is_digit(c) || clex_pkg::is_alpha(c) ||
              (c == clex_pkg::CH_UNDERSCORE);
      end
      clex_pkg::MODE_EQ: begin
        pair      = (c == clex_pkg::CH_EQUAL);
        pair_kind = clex_pkg::TK_EQ;
      end
      clex_pkg::MODE_PLUS: begin
        pair      = (c == clex_pkg::CH_PLUS) || (c == clex_pkg::CH_EQUAL);
        pair_kind = (c == clex_pkg::CH_PLUS) ? clex_pkg::TK_INC : clex_pkg::TK_ADDEQ;
      end
      clex_pkg::MODE_MINUS: begin
        pair      = (c == clex_pkg::CH_MINUS) || (c == clex_pkg::CH_EQUAL);
        pair_kind = (c == clex_pkg::CH_MINUS) ? clex_pkg::TK_DEC : clex_pkg::TK_SUBEQ;
      end
      default: begin
        ext  = 1'b0;
        pair = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    tstart_d = tstart_q;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    tcnt_d   = tcnt_q;
    pre_d    = pre_q;
    off_d    = off_q;
    line_d   = line_q;
    col_d    = col_q;
    a_v      = 1'b0;
    a_tok    = flush_tok;
    b_v      = 1'b0;
    b_tok    = flush_tok;
    if (acc) begin
      if (is_end) begin
        // Flush the pending token, then the end token at the current position.
        a_v    = pend;
        b_v    = 1'b1;
        b_tok  = {col_q, line_q, clex_pkg::LEN_W'(0), off_q, clex_pkg::TK_EOF};
        mode_d = clex_pkg::MODE_IDLE;
      end else if (ext) begin
        if (mode_q == clex_pkg::MODE_NUM && clex_pkg::is_alpha(c)) begin
          mode_d = clex_pkg::MODE_BADNUM;
        end
        if (tcnt_q < clex_pkg::LEN_PREFIX) begin
          pre_d = {pre_q[clex_pkg::PREFIX_W-9:0], c};
        end
        tcnt_d = tcnt_inc;
        off_d  = off_nx;
        line_d = line_nx;
        col_d  = col_nx;
      end else if (pair) begin
        a_v    = 1'b1;
        a_tok  = {tcol_q, tline_q, clex_pkg::LEN_TWO, tstart_q, pair_kind};
        mode_d = clex_pkg::MODE_IDLE;
        off_d  = off_nx;
        line_d = line_nx;
        col_d  = col_nx;
      end else begin
        // The byte ends the pending token and is scanned afresh.
        a_v    = pend;
        mode_d = clex_pkg::MODE_IDLE;
        off_d  = off_nx;
        line_d = line_nx;
        col_d  = col_nx;
        if (!clex_pkg::is_space(c)) begin
          tstart_d = off_q;
          tline_d  = line_q;
          tcol_d   = col_q;
          tcnt_d   = clex_pkg::LEN_ONE;
          pre_d    = {{(clex_pkg::PREFIX_W-8){1'b0}}, c};
          if (clex_pkg::is_digit(c)) begin
            mode_d = clex_pkg::MODE_NUM;
          end else if (clex_pkg::is_alpha(c) || c == clex_pkg::CH_UNDERSCORE) begin
            mode_d = clex_pkg::MODE_IDENT;
          end else if (c == clex_pkg::CH_EQUAL) begin
            mode_d = clex_pkg::MODE_EQ;
          end else if (c == clex_pkg::CH_PLUS) begin
            mode_d = clex_pkg::MODE_PLUS;
          end else if (c == clex_pkg::CH_MINUS) begin
            mode_d = clex_pkg::MODE_MINUS;
          end else begin
            b_v   = 1'b1;
            b_tok = {col_q, line_q, clex_pkg::LEN_ONE, off_q, clex_pkg::single_kind(c)};
          end
        end
      end
    end
  end

  // Entry layout: token count on top, second token, first token at the bottom.
  assign push_o  = a_v || b_v;
  assign entry_o = {{1'b0, a_v} + {1'b0, b_v}, b_tok, (a_v ? a_tok : b_tok)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= clex_pkg::MODE_IDLE;
      tstart_q <= '0;
      tline_q  <= LB'(1);
      tcol_q   <= CB'(1);
      tcnt_q   <= '0;
      pre_q    <= '0;
      off_q    <= '0;
      line_q   <= LB'(1);
      col_q    <= CB'(1);
    end else begin
      mode_q   <= mode_d;
      tstart_q <= tstart_d;
      tline_q  <= tline_d;
      tcol_q   <= tcol_d;
      tcnt_q   <= tcnt_d;
      pre_q    <= pre_d;
      off_q    <= off_d;
      line_q   <= line_d;
      col_q    <= col_d;
    end
  end

`ifndef SYNTHESIS
  a_end_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_end) |=> (mode_q == clex_pkg::MODE_IDLE && $stable(off_q)))
    else $error("end of source left a pending token or moved the offset");
`endif

endmodule

`default_nettype wire

[rtl/clex_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Output stage: holds one queue entry and hands out its tokens one per
// transaction, marking the final token of the entry with tlast.
module clex_emit #(
  parameter int unsigned TOK_W  = 81,
  parameter int unsigned ENT_W  = clex_pkg::CNT2_W + 2 * TOK_W,
  parameter int unsigned DATA_W = 88
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ENT_W-1:0]  entry_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  output logic [DATA_W-1:0]      m_data_o,
  output logic                   m_last_o
);

  logic [ENT_W-1:0] ent_q;
  logic             ent_valid_q;
  logic             idx_q;
  logic [clex_pkg::CNT2_W-1:0] ent_cnt;
  logic [TOK_W-1:0] tok;
  logic fire, load;

  assign ent_cnt   = ent_q[ENT_W-1 -: clex_pkg::CNT2_W];
  assign tok       = idx_q ? ent_q[2*TOK_W-1:TOK_W] : ent_q[TOK_W-1:0];
  assign m_valid_o = ent_valid_q;
  assign m_last_o  = idx_q || (ent_cnt == 2'd1);
  assign fire      = ent_valid_q && m_ready_i;
  assign load      = !ent_valid_q || (fire && m_last_o);
  assign pop_o     = load && !empty_i;

  always_comb begin
    m_data_o             = '0;
    m_data_o[TOK_W-1:0]  = tok;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else if (pop_o) begin
      ent_valid_q <= 1'b1;
      idx_q       <= 1'b0;
    end else if (fire && m_last_o) begin
      ent_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else if (fire) begin
      idx_q       <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_entry_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_valid_q |-> (ent_cnt == 2'd1 || ent_cnt == 2'd2))
    else $error("held entry carries no token");
`endif

endmodule

`default_nettype wire

[rtl/c_subset_lexer_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer for a small C subset.
// Slave channel: one source byte per transaction in s_axis_tdata_i; s_axis_tuser_i
// set means the source has ended (a zero byte means the same). Either one
// flushes the pending token and then yields an end-of-file token.
// Master channel: one token per transaction. tlast marks the final token caused
// by one input byte; a byte causes zero, one or two tokens.
// Throughput: one byte per cycle and one token per cycle, limited only by the
// output stage when bytes produce tokens faster than one per cycle.
// A token is written into the queue when the byte that completes it is accepted,
// then moves from the queue into the output stage register that drives the master side.
// A four-entry token queue sits between the scanner and the output stage, so
// bytes keep flowing while a result waits; when the receiver stalls and the
// queue fills, s_axis_tready_o drops until an entry drains.
// Reset clears the scanner to idle, the position to offset 0, line 1, column 1,
// and empties the queue and the output stage.
module c_subset_lexer_top #(
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned LINE_BITS   = 20,
  parameter int unsigned COLUMN_BITS = 16,
  localparam int unsigned TOK_W  = clex_pkg::KIND_W + OFFSET_BITS + clex_pkg::LEN_W +
                                   LINE_BITS + COLUMN_BITS,
  localparam int unsigned DATA_W = ((TOK_W + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // Fields from bit 0: source_byte.
  input  wire logic [7:0]        s_axis_tdata_i,
  // Fields from bit 0: end_of_source.
  input  wire logic              s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // Fields from bit 0: token_kind, start_offset, token_length, first_line,
  // start_column, then zero padding to a whole byte.
  output logic [DATA_W-1:0]      m_axis_tdata_o,
  // Last token caused by the input byte.
  output logic                   m_axis_tlast_o
);

  localparam int unsigned ENT_W = clex_pkg::CNT2_W + 2 * TOK_W;

  logic             push, pop, full, empty;
  logic [ENT_W-1:0] push_entry, pop_entry;

  clex_scan #(
    .OB    (OFFSET_BITS),
    .LB    (LINE_BITS),
    .CB    (COLUMN_BITS),
    .TOK_W (TOK_W),
    .ENT_W (ENT_W)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_end_i   (s_axis_tuser_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  clex_fifo #(
    .WIDTH (ENT_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (empty)
  );

  clex_emit #(
    .TOK_W  (TOK_W),
    .ENT_W  (ENT_W),
    .DATA_W (DATA_W)
  ) u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .entry_i   (pop_entry),
    .empty_i   (empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  a_ready_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == !full)
    else $error("input ready disagrees with queue space");
`endif

endmodule

`default_nettype wire
